>>> rtl/core/rgbhsv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared widths, constants and types of the rgb to hsv pixel converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

   localparam int PIX_W         = 8;    // width of every color channel
   localparam int NUM_W         = 16;   // dividend width of both divisions
   localparam int DIV_BITS      = 2;    // quotient bits resolved per stage
   localparam int DIV_STAGES    = PIX_W / DIV_BITS;
   localparam int PIPE_DEPTH    = DIV_STAGES + 3;
   localparam int BEAT_W        = 3 * PIX_W;

   localparam int HUE_SIXTH     = 30;
   localparam int HUE_HALF_TURN = 180;
   localparam int FULL_SCALE    = 255;

   typedef enum logic [1:0] {
      SECTOR_RED   = 2'd0,
      SECTOR_GREEN = 2'd1,
      SECTOR_BLUE  = 2'd2
   } sector_type;

   typedef struct packed {
      logic [DIV_STAGES-1:0] step_en;
      logic                  round_en;
   } div_ctl_type;

endpackage

>>> rtl/core/rgbhsv_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbhsv_divider
// Pipelined restoring divider with round half to even; the quotient is known
// to fit in one channel width. A zero flag forces the result to zero.
// ----------------------------------------------------------------------------
module rgbhsv_divider
   import rgbhsv_pkg::*;
(
   input  logic              clock,
   input  div_ctl_type       ctl,
   input  logic [NUM_W-1:0]  num,
   input  logic [PIX_W-1:0]  den,
   input  logic              zero,
   output logic [PIX_W-1:0]  quot
);

   logic [NUM_W-1:0] rem_ff  [DIV_STAGES];
   logic [NUM_W-1:0] rem_in  [DIV_STAGES];
   logic [PIX_W-1:0] q_ff    [DIV_STAGES];
   logic [PIX_W-1:0] q_in    [DIV_STAGES];
   logic [PIX_W-1:0] den_ff  [DIV_STAGES];
   logic [PIX_W-1:0] den_src [DIV_STAGES];
   logic [NUM_W-1:0] rem_src [DIV_STAGES];
   logic [PIX_W-1:0] q_src   [DIV_STAGES];
   logic             zero_ff [DIV_STAGES];
   logic             zero_src[DIV_STAGES];

   logic [PIX_W-1:0] quot_ff;
   logic [PIX_W-1:0] quot_in;
   logic [PIX_W:0]   rem_twice;
   logic [PIX_W:0]   den_wide;
   logic             round_up;

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_step
      if (j == 0) begin : g_first
         assign rem_src[j]  = num;
         assign q_src[j]    = '0;
         assign den_src[j]  = den;
         assign zero_src[j] = zero;
      end else begin : g_next
         assign rem_src[j]  = rem_ff[j-1];
         assign q_src[j]    = q_ff[j-1];
         assign den_src[j]  = den_ff[j-1];
         assign zero_src[j] = zero_ff[j-1];
      end

      // two compare-and-subtract steps, highest quotient bit first
      always_comb begin
         rem_in[j] = rem_src[j];
         q_in[j]   = q_src[j];
         for (int b = 0; b < DIV_BITS; b++) begin
            if (rem_in[j] >= (NUM_W'(den_src[j]) << (PIX_W - 1 - j * DIV_BITS - b))) begin
               rem_in[j] = rem_in[j] - (NUM_W'(den_src[j]) << (PIX_W - 1 - j * DIV_BITS - b));
               q_in[j]   = q_in[j] | (PIX_W'(1) << (PIX_W - 1 - j * DIV_BITS - b));
            end
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.step_en[j]) begin
            rem_ff[j]  <= rem_in[j];
            q_ff[j]    <= q_in[j];
            den_ff[j]  <= den_src[j];
            zero_ff[j] <= zero_src[j];
         end
      end
   end

   // remainder is below the divisor, so its low byte holds it
   always_comb begin
      rem_twice = {rem_ff[DIV_STAGES-1][PIX_W-1:0], 1'b0};
      den_wide  = {1'b0, den_ff[DIV_STAGES-1]};
      round_up  = (rem_twice > den_wide) ||
                  ((rem_twice == den_wide) && q_ff[DIV_STAGES-1][0]);
      quot_in   = zero_ff[DIV_STAGES-1] ? '0 :
                  q_ff[DIV_STAGES-1] + PIX_W'(round_up);
   end

   always_ff @(posedge clock) begin
      if (ctl.round_en) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

>>> rtl/core/rgb_to_hsv_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel
// 8-bit rgb pixel to hsv with hue in units of two degrees (0..180), saturation
// 0..255 and value as the largest channel, all rounded half to even.
//
//   channel | direction | tdata fields (low bit up)
//   req_    | in        | red, green, blue
//   rsp_    | out       | hue, saturation, brightness
//
// one pixel per cycle sustained while rsp_tready holds; stages in order: min/max,
// numerators, four divider stages of two quotient bits each, then rounding
// into the output register. hue and saturation use twin divider pipelines.
// reset clears only the valid bits. a stalled output holds its beat while
// empty stages upstream keep filling, so bubbles are squeezed out.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel
   import rgbhsv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BEAT_W-1:0] req_tdata,   // red, green, blue
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BEAT_W-1:0] rsp_tdata    // hue, saturation, brightness
);

   logic [PIPE_DEPTH-1:0] valid_ff;
   logic [PIPE_DEPTH-1:0] valid_in;
   logic [PIPE_DEPTH-1:0] stage_rdy;
   logic [PIPE_DEPTH-1:0] prev_valid;

   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;

   // stage 0: extremes, sector and signed channel difference
   logic [PIX_W-1:0]        mx_in;
   logic [PIX_W-1:0]        mn_in;
   sector_type              sector_in;
   logic signed [PIX_W:0]   diff_in;
   logic [PIX_W-1:0]        mx_ff;
   logic [PIX_W-1:0]        mn_ff;
   sector_type              sector_ff;
   logic signed [PIX_W:0]   diff_ff;

   // stage 1: numerators and divisors
   localparam int HN_W = NUM_W + 2;
   logic [PIX_W-1:0]        delta;
   logic signed [HN_W-1:0]  delta_s;
   logic signed [HN_W-1:0]  hue_raw;
   logic [NUM_W-1:0]        hue_num_in;
   logic [NUM_W-1:0]        sat_num_in;
   logic [NUM_W-1:0]        hue_num_ff;
   logic [NUM_W-1:0]        sat_num_ff;
   logic [PIX_W-1:0]        delta_ff;
   logic                    grey_ff;

   logic [PIX_W-1:0] mx_pipe_ff [1:PIPE_DEPTH-1];
   logic [PIX_W-1:0] hue_q;
   logic [PIX_W-1:0] sat_q;
   div_ctl_type      div_ctl;

   assign red   = req_tdata[PIX_W-1:0];
   assign green = req_tdata[2*PIX_W-1:PIX_W];
   assign blue  = req_tdata[3*PIX_W-1:2*PIX_W];

   // ready ripples back from the output; a stage takes a beat when empty
   // or when its own beat moves on
   assign prev_valid = {valid_ff[PIPE_DEPTH-2:0], req_tvalid};

   always_comb begin
      for (int k = PIPE_DEPTH - 1; k >= 0; k--) begin
         if (k == PIPE_DEPTH - 1) begin
            stage_rdy[k] = !valid_ff[k] || rsp_tready;
         end else begin
            stage_rdy[k] = !valid_ff[k] || stage_rdy[k+1];
         end
         valid_in[k] = stage_rdy[k] ? prev_valid[k] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_rdy[0];

   // red wins ties, then green
   always_comb begin
      if (red >= green && red >= blue) begin
         sector_in = SECTOR_RED;
         mx_in     = red;
         diff_in   = $signed({1'b0, green}) - $signed({1'b0, blue});
      end else if (green >= blue) begin
         sector_in = SECTOR_GREEN;
         mx_in     = green;
         diff_in   = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         sector_in = SECTOR_BLUE;
         mx_in     = blue;
         diff_in   = $signed({1'b0, red}) - $signed({1'b0, green});
      end
      mn_in = red;
      if (green < mn_in) begin
         mn_in = green;
      end
      if (blue < mn_in) begin
         mn_in = blue;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[0]) begin
         mx_ff     <= mx_in;
         mn_ff     <= mn_in;
         sector_ff <= sector_in;
         diff_ff   <= diff_in;
      end
   end

   // hue numerator in units of two degrees over delta, wrapped into 0..180*delta
   always_comb begin
      delta   = mx_ff - mn_ff;
      delta_s = $signed({{(HN_W-PIX_W){1'b0}}, delta});
      case (sector_ff)
         SECTOR_RED:   hue_raw = HN_W'(HUE_SIXTH) * HN_W'(diff_ff);
         SECTOR_GREEN: hue_raw = HN_W'(HUE_SIXTH) * HN_W'(diff_ff)
                               + HN_W'(2 * HUE_SIXTH) * delta_s;
         SECTOR_BLUE:  hue_raw = HN_W'(HUE_SIXTH) * HN_W'(diff_ff)
                               + HN_W'(4 * HUE_SIXTH) * delta_s;
         default:      hue_raw = '0;
      endcase
      if (hue_raw < 0) begin
         hue_raw = hue_raw + HN_W'(HUE_HALF_TURN) * delta_s;
      end
      hue_num_in = hue_raw[NUM_W-1:0];
      sat_num_in = NUM_W'(FULL_SCALE) * NUM_W'(delta);
   end

   always_ff @(posedge clock) begin
      if (stage_rdy[1]) begin
         hue_num_ff <= hue_num_in;
         sat_num_ff <= sat_num_in;
         delta_ff   <= delta;
         grey_ff    <= (delta == '0);
      end
   end

   // value rides alongside the dividers
   for (genvar k = 1; k < PIPE_DEPTH; k++) begin : g_mx
      if (k == 1) begin : g_first
         always_ff @(posedge clock) begin
            if (stage_rdy[k]) begin
               mx_pipe_ff[k] <= mx_ff;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (stage_rdy[k]) begin
               mx_pipe_ff[k] <= mx_pipe_ff[k-1];
            end
         end
      end
   end

   assign div_ctl.step_en  = stage_rdy[DIV_STAGES+1:2];
   assign div_ctl.round_en = stage_rdy[PIPE_DEPTH-1];

   rgbhsv_divider u_hue_div (
      .clock (clock),
      .ctl   (div_ctl),
      .num   (hue_num_ff),
      .den   (delta_ff),
      .zero  (grey_ff),
      .quot  (hue_q)
   );

   rgbhsv_divider u_sat_div (
      .clock (clock),
      .ctl   (div_ctl),
      .num   (sat_num_ff),
      .den   (mx_pipe_ff[1]),
      .zero  (grey_ff),
      .quot  (sat_q)
   );

   assign rsp_tvalid = valid_ff[PIPE_DEPTH-1];
   assign rsp_tdata  = {mx_pipe_ff[PIPE_DEPTH-1], sat_q, hue_q};

   // hue never passes 180, one full turn
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[PIX_W-1:0] <= PIX_W'(HUE_HALF_TURN))
      else $error("hue out of range");

   // black is always grey
   a_black_grey: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3*PIX_W-1:2*PIX_W] == '0 |->
         rsp_tdata[2*PIX_W-1:PIX_W] == '0)
      else $error("nonzero saturation on black pixel");

   // zero saturation only for grey pixels, which carry zero hue
   a_grey_hue: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2*PIX_W-1:PIX_W] == '0 |->
         rsp_tdata[PIX_W-1:0] == '0)
      else $error("grey pixel with nonzero hue");

   // a held output beat keeps the stage behind it from overwriting it
   a_hold_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("output beat lost under stall");

endmodule
